### rtl/core/cacc_pkg.sv
// ----------------------------------------------------------------------------
// cacc_pkg
// Shared types, codes and saturation helpers for the complex accumulator ALU.
// ----------------------------------------------------------------------------
package cacc_pkg;

  // Action codes carried by each input item.
  typedef enum logic [2:0] {
    ACT_LOAD = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4
  } action_e;

  // Product slots filled by the shared multiplier.
  localparam int unsigned PROD_NUM = 6;
  localparam logic [2:0] P_AR_BR = 3'd0;
  localparam logic [2:0] P_AI_BI = 3'd1;
  localparam logic [2:0] P_AR_BI = 3'd2;
  localparam logic [2:0] P_AI_BR = 3'd3;
  localparam logic [2:0] P_BR_BR = 3'd4;
  localparam logic [2:0] P_BI_BI = 3'd5;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  // Request to the shared multiplier.
  typedef struct packed {
    logic       vld;
    logic [2:0] tag;
  } mul_req_t;

  // Status and quotient from the divider.
  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [31:0] quot;
  } div_res_t;

  // A clipped 32-bit part together with its clip flag.
  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clamp_t;

  // Clip a wide signed value to the 32-bit two's complement range.
  function automatic clamp_t clamp32(input logic signed [65:0] v);
    clamp_t r;
    if (v > S32_MAX) begin
      r.val = POS_LIMIT;
      r.sat = 1'b1;
    end else if (v < S32_MIN) begin
      r.val = NEG_LIMIT;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // Apply the sign to an unsigned quotient and clip it.
  function automatic clamp_t div_fix(input logic neg, input logic ovf,
                                     input logic [31:0] quot);
    clamp_t r;
    logic signed [65:0] qs;
    qs = $signed({34'd0, quot});
    if (ovf) begin
      r.val = neg ? NEG_LIMIT : POS_LIMIT;
      r.sat = 1'b1;
    end else begin
      r = clamp32(neg ? -qs : qs);
    end
    return r;
  endfunction

endpackage

### rtl/core/cacc_mul.sv
// ----------------------------------------------------------------------------
// cacc_mul
// Shared signed 32x32 multiplier with a registered product and tag.
// ----------------------------------------------------------------------------
module cacc_mul
  import cacc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mul_req_t           req_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output mul_req_t           rsp_o,
  output logic signed [63:0] prod_o
);

  mul_req_t           rsp_q;
  logic signed [63:0] prod_q;

  // The tag and valid travel alongside the product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_q <= '0;
    end else begin
      rsp_q <= req_i;
    end
  end

  // Product register; a single multiply sits in front of it.
  always_ff @(posedge clk_i) begin
    if (req_i.vld) begin
      prod_q <= a_i * b_i;
    end
  end

  assign rsp_o  = rsp_q;
  assign prod_o = prod_q;

endmodule

### rtl/core/cacc_div.sv
// ----------------------------------------------------------------------------
// cacc_div
// Restoring divider: floor(mag * 2^FRAC_BITS / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cacc_div
  import cacc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] mag_i,
  input  logic [63:0] den_i,
  output div_res_t    res_o
);

  localparam int NW = 64 + FRAC_BITS;

  logic [NW-1:0] num;
  logic [NW-33:0] num_hi;
  logic [63:0]   hi_ext;
  logic          ovf_start;
  logic          busy_q, done_q, ovf_q;
  logic [4:0]    cnt_q;
  logic [63:0]   rem_q, den_q;
  logic [31:0]   low_q, quot_q;
  logic [64:0]   shifted, diff;
  logic          ge;

  // The scaled numerator; its upper part seeds the remainder.
  assign num       = {mag_i, {FRAC_BITS{1'b0}}};
  assign num_hi    = num[NW-1:32];
  assign hi_ext    = {{(32 - FRAC_BITS){1'b0}}, num_hi};
  assign ovf_start = (hi_ext >= den_i);

  // One shift, compare and subtract step.
  assign shifted = {rem_q, low_q[31]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = (shifted >= {1'b0, den_q});

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        ovf_q  <= ovf_start;
        done_q <= ovf_start;
        busy_q <= !ovf_start;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder, pending numerator bits and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= hi_ext;
      low_q  <= num[31:0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[63:0] : shifted[63:0];
      low_q  <= {low_q[30:0], 1'b0};
      quot_q <= {quot_q[30:0], ge};
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quot = quot_q;

endmodule

### rtl/core/complex_accumulator_alu.sv
// ----------------------------------------------------------------------------
// complex_accumulator_alu
// Complex accumulator in signed fixed point with load, add, subtract,
// multiply and divide actions.
// ----------------------------------------------------------------------------
// One item is handled at a time and in_stall_o is high until its result has
// been taken. Load, add, subtract and the unused codes go from ST_IDLE
// through ST_EXEC to a registered result. Multiply makes four passes through
// the one shared 32x32 multiplier. Divide makes six passes through the
// multiplier, then two 32-step runs of the bit-serial divider, one for each
// part. Multiply rounds toward minus infinity, divide truncates toward zero,
// and parts outside the 32-bit range are clipped with saturated_o set. A
// divide by zero keeps the accumulator and sets divide_by_zero_o.
module complex_accumulator_alu
  import cacc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] operand_real_i,
  input  logic signed [31:0] operand_imag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_real_o,
  output logic signed [31:0] result_imag_o,
  output logic               divide_by_zero_o,
  output logic               saturated_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EXEC = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_WAIT = 7'b0001000,
    ST_COMB = 7'b0010000,
    ST_DIVR = 7'b0100000,
    ST_DIVI = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_q, out_d;

  logic [2:0]         act_q;
  logic signed [31:0] br_q, bi_q;
  logic signed [31:0] acc_r_q, acc_i_q, acc_r_d, acc_i_d;
  logic [31:0]        res_r_q, res_i_q, res_r_d, res_i_d;
  logic               dz_q, dz_d, sat_q, sat_d;
  logic [2:0]         idx_q, idx_d;
  logic signed [63:0] prod_q [PROD_NUM];

  mul_req_t           mul_req, mul_rsp;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  logic               div_start;
  logic [63:0]        div_mag;
  div_res_t           div_res;

  logic signed [65:0] mul_re, mul_im, num_re, num_im;
  logic [63:0]        mag_re, mag_im, den;
  logic               neg_re, neg_im, in_acc, out_acc;
  logic [2:0]         idx_last;
  clamp_t             c_r, c_i;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_q && !out_stall_i;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (idx_q)
      P_AR_BR: begin mul_a = acc_r_q; mul_b = br_q; end
      P_AI_BI: begin mul_a = acc_i_q; mul_b = bi_q; end
      P_AR_BI: begin mul_a = acc_r_q; mul_b = bi_q; end
      P_AI_BR: begin mul_a = acc_i_q; mul_b = br_q; end
      P_BR_BR: begin mul_a = br_q;    mul_b = br_q; end
      default: begin mul_a = bi_q;    mul_b = bi_q; end
    endcase
  end

  assign mul_req.vld = (state_q == ST_MUL);
  assign mul_req.tag = idx_q;

  cacc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .rsp_o  (mul_rsp),
    .prod_o (mul_p)
  );

  // Products land in their slots as they leave the multiplier.
  always_ff @(posedge clk_i) begin
    if (mul_rsp.vld) begin
      prod_q[mul_rsp.tag] <= mul_p;
    end
  end

  // Sums of products for multiply and divide.
  assign mul_re = 66'(prod_q[P_AR_BR]) - 66'(prod_q[P_AI_BI]);
  assign mul_im = 66'(prod_q[P_AR_BI]) + 66'(prod_q[P_AI_BR]);
  assign num_re = 66'(prod_q[P_AR_BR]) + 66'(prod_q[P_AI_BI]);
  assign num_im = 66'(prod_q[P_AI_BR]) - 66'(prod_q[P_AR_BI]);
  assign neg_re = num_re[65];
  assign neg_im = num_im[65];
  assign mag_re = neg_re ? 64'(-num_re) : num_re[63:0];
  assign mag_im = neg_im ? 64'(-num_im) : num_im[63:0];
  assign den    = prod_q[P_BR_BR] + prod_q[P_BI_BI];

  assign div_mag = (state_q == ST_DIVR) ? mag_im : mag_re;

  cacc_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (div_mag),
    .den_i   (den),
    .res_o   (div_res)
  );

  assign idx_last = (act_q == ACT_MUL) ? P_AI_BR : P_BI_BI;

  // Sequencer: steps each item through the shared units.
  always_comb begin
    state_d   = state_q;
    out_d     = out_q;
    acc_r_d   = acc_r_q;
    acc_i_d   = acc_i_q;
    res_r_d   = res_r_q;
    res_i_d   = res_i_q;
    dz_d      = dz_q;
    sat_d     = sat_q;
    idx_d     = idx_q;
    div_start = 1'b0;
    c_r       = '0;
    c_i       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (out_acc) begin
          out_d = 1'b0;
        end
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        dz_d  = 1'b0;
        sat_d = 1'b0;
        idx_d = '0;
        case (act_q)
          ACT_LOAD: begin
            res_r_d = br_q;
            res_i_d = bi_q;
          end
          ACT_ADD: begin
            c_r     = clamp32(66'(acc_r_q) + 66'(br_q));
            c_i     = clamp32(66'(acc_i_q) + 66'(bi_q));
            res_r_d = c_r.val;
            res_i_d = c_i.val;
            sat_d   = c_r.sat | c_i.sat;
          end
          ACT_SUB: begin
            c_r     = clamp32(66'(acc_r_q) - 66'(br_q));
            c_i     = clamp32(66'(acc_i_q) - 66'(bi_q));
            res_r_d = c_r.val;
            res_i_d = c_i.val;
            sat_d   = c_r.sat | c_i.sat;
          end
          ACT_MUL, ACT_DIV: begin
            state_d = ST_MUL;
          end
          default: begin
            res_r_d = acc_r_q;
            res_i_d = acc_i_q;
          end
        endcase
        if (state_d == ST_EXEC) begin
          acc_r_d = res_r_d;
          acc_i_d = res_i_d;
          out_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        idx_d = idx_q + 3'd1;
        if (idx_q == idx_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_COMB;
      end
      ST_COMB: begin
        if (act_q == ACT_MUL) begin
          c_r     = clamp32(mul_re >>> FRAC_BITS);
          c_i     = clamp32(mul_im >>> FRAC_BITS);
          res_r_d = c_r.val;
          res_i_d = c_i.val;
          sat_d   = c_r.sat | c_i.sat;
          acc_r_d = c_r.val;
          acc_i_d = c_i.val;
          out_d   = 1'b1;
          state_d = ST_IDLE;
        end else if (den == 64'd0) begin
          res_r_d = acc_r_q;
          res_i_d = acc_i_q;
          dz_d    = 1'b1;
          out_d   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (div_res.done) begin
          c_r       = div_fix(neg_re, div_res.ovf, div_res.quot);
          res_r_d   = c_r.val;
          sat_d     = c_r.sat;
          div_start = 1'b1;
          state_d   = ST_DIVI;
        end
      end
      ST_DIVI: begin
        if (div_res.done) begin
          c_i     = div_fix(neg_im, div_res.ovf, div_res.quot);
          res_i_d = c_i.val;
          sat_d   = sat_q | c_i.sat;
          acc_r_d = res_r_q;
          acc_i_d = c_i.val;
          out_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and accumulator registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_q   <= 1'b0;
      acc_r_q <= '0;
      acc_i_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      out_q   <= out_d;
      acc_r_q <= acc_r_d;
      acc_i_q <= acc_i_d;
      idx_q   <= idx_d;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= action_i;
      br_q  <= operand_real_i;
      bi_q  <= operand_imag_i;
    end
    res_r_q <= res_r_d;
    res_i_q <= res_i_d;
    dz_q    <= dz_d;
    sat_q   <= sat_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE) || out_q;
  assign out_valid_o      = out_q;
  assign result_real_o    = res_r_q;
  assign result_imag_o    = res_i_q;
  assign divide_by_zero_o = dz_q;
  assign saturated_o      = sat_q;

endmodule

### rtl/core/cacc_chk.sv
// ----------------------------------------------------------------------------
// cacc_chk
// Port-level checks for the complex accumulator ALU, bound to the top level.
// ----------------------------------------------------------------------------
module cacc_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic divide_by_zero_o,
  input logic saturated_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // No new item is taken while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // An accepted item never shows its result in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result appeared too early");

  // At most one result per item: a taken result is not offered again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result repeated");

  // A zero divisor never reports clipping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> !saturated_o)
    else $error("zero divisor with saturation");

endmodule

bind complex_accumulator_alu cacc_chk u_cacc_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .divide_by_zero_o (divide_by_zero_o),
  .saturated_o      (saturated_o)
);
